[design/dcm_pkg.sv]
`timescale 1ns / 1ps

package dcm_pkg;

    localparam int ST_W      = 7;
    localparam int SYM_W     = 8;
    localparam int ADDR_W    = ST_W + SYM_W;
    localparam int TBL_DEPTH = 1 << ADDR_W;
    localparam int WORD_W    = 32;
    localparam int ACT_W     = 16;
    localparam int POS_W     = 16;
    localparam int CAP_SLOTS = 16;
    localparam int CID_W     = 4;
    localparam int CNT_W     = 4;
    localparam int CFG_W     = 8;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;

    localparam logic [ST_W-1:0]  ANY_STATE  = 7'd1;
    localparam logic [POS_W-1:0] POS_LIMIT  = 16'hFFFE;
    localparam int               ACT_MATCH  = 15;
    localparam int               ACT_DONE   = 14;

    localparam logic [CFG_W-1:0] WILDCARD_RST = 8'd42;
    localparam logic [CNT_W-1:0] LIMIT_RST    = 4'd15;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_DATA = 1'b1;

    localparam logic KIND_CAPTURE = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [1:0] STOP_END   = 2'd0;
    localparam logic [1:0] STOP_DONE  = 2'd1;
    localparam logic [1:0] STOP_LIMIT = 2'd2;

    localparam logic CFG_WILDCARD = 1'b0;
    localparam logic CFG_LIMIT    = 1'b1;

    typedef struct packed {
        logic              func;
        logic [ST_W-1:0]   table_state;
        logic [SYM_W-1:0]  table_symbol;
        logic [WORD_W-1:0] table_word;
        logic [SYM_W-1:0]  data_byte;
        logic              end_of_message;
    } t_in_item;

    typedef struct packed {
        logic              kind;
        logic [CID_W-1:0]  capture_id;
        logic [POS_W-1:0]  start_res;
        logic [POS_W-1:0]  length;
        logic [CNT_W-1:0]  match_count;
        logic [1:0]        stop_reason;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr0;
        logic [ADDR_W-1:0] raddr1;
    } t_ram_req;

    typedef struct packed {
        logic      push_a;
        logic      push_b;
        t_out_item item_a;
        t_out_item item_b;
    } t_push;

endpackage

[design/dcm_table_ram.sv]
`timescale 1ns / 1ps

module dcm_table_ram (
    input  logic                        i_clk,
    input  dcm_pkg::t_ram_req           i_req,
    output logic [dcm_pkg::WORD_W-1:0]  o_rd0,
    output logic [dcm_pkg::WORD_W-1:0]  o_rd1
);
    import dcm_pkg::*;

    logic [WORD_W-1:0] r_mem [TBL_DEPTH];
    logic [WORD_W-1:0] r_rd0;
    logic [WORD_W-1:0] r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd0 <= r_mem[i_req.raddr0];
            r_rd1 <= r_mem[i_req.raddr1];
        end
    end

    assign o_rd0 = r_rd0;
    assign o_rd1 = r_rd1;

endmodule

[design/dcm_result_fifo.sv]
`timescale 1ns / 1ps

module dcm_result_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dcm_pkg::t_push     i_push,
    output logic               o_free2,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dcm_pkg::t_out_item o_out_data
);
    import dcm_pkg::*;

    t_out_item            r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_head;
    logic [OUT_PTR_W-1:0] r_tail;
    logic [OUT_PTR_W:0]   r_cnt;
    logic [OUT_PTR_W-1:0] n_head;
    logic [OUT_PTR_W-1:0] n_tail;
    logic [OUT_PTR_W:0]   n_cnt;
    logic                 pop;
    logic [OUT_PTR_W:0]   push_n;

    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_mem[r_head];
    assign o_free2     = (r_cnt <= (OUT_PTR_W+1)'(OUT_DEPTH - 2));
    assign pop         = o_out_valid && i_out_ready;

    always_comb begin
        push_n = (OUT_PTR_W+1)'(i_push.push_a) + (OUT_PTR_W+1)'(i_push.push_b);
        n_head = pop ? OUT_PTR_W'(r_head + 1'b1) : r_head;
        n_tail = OUT_PTR_W'(r_tail + push_n[OUT_PTR_W-1:0]);
        n_cnt  = (OUT_PTR_W+1)'(r_cnt + push_n - (OUT_PTR_W+1)'(pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push_a) begin
            r_mem[r_tail] <= i_push.item_a;
        end
        if (i_push.push_b) begin
            r_mem[OUT_PTR_W'(r_tail + 1'b1)] <= i_push.item_b;
        end
    end

endmodule

[design/dcm_engine.sv]
`timescale 1ns / 1ps

module dcm_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  dcm_pkg::t_in_item             i_in_data,
    input  logic [dcm_pkg::SYM_W-1:0]     i_wildcard,
    input  logic [dcm_pkg::CNT_W-1:0]     i_limit,
    input  logic                          i_free2,
    input  logic [dcm_pkg::WORD_W-1:0]    i_rd0,
    input  logic [dcm_pkg::WORD_W-1:0]    i_rd1,
    output dcm_pkg::t_ram_req             o_req,
    output dcm_pkg::t_push                o_push
);
    import dcm_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK1 = 2'd2;
    localparam logic [1:0] S_LOOK2 = 2'd3;

    logic [1:0]        r_state,  n_state;
    logic [ADDR_W-1:0] r_clr,    n_clr;
    logic              r_in_vld, n_in_vld;
    t_in_item          r_in;
    logic [SYM_W-1:0]  r_byte,   n_byte;
    logic              r_eom,    n_eom;
    logic [ST_W-1:0]   r_mst,    n_mst;
    logic [POS_W-1:0]  r_pos,    n_pos;
    logic [CNT_W-1:0]  r_cnt,    n_cnt;
    logic [1:0]        r_halt,   n_halt;
    logic [POS_W-1:0]  r_starts [CAP_SLOTS];
    logic [POS_W-1:0]  n_starts [CAP_SLOTS];

    logic              take;
    logic              accept;
    logic [WORD_W-1:0] w;
    logic [ST_W-1:0]   nxt;
    logic [ACT_W-1:0]  act;
    logic [CID_W-1:0]  cid;
    logic [POS_W-1:0]  st;
    logic [CNT_W-1:0]  cnt1;
    logic              stepped;
    logic              summary;
    t_out_item         cap_item;
    t_out_item         sum_item;

    function automatic logic [WORD_W-1:0] pick(input logic [WORD_W-1:0] a,
                                               input logic [WORD_W-1:0] b);
        pick = (a != '0) ? a : b;
    endfunction

    assign take       = (r_state == S_IDLE) && r_in_vld && i_free2;
    assign o_in_ready = i_rst_n && (!r_in_vld || take);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_in_vld = take ? accept : (r_in_vld || accept);
        n_byte   = r_byte;
        n_eom    = r_eom;
        n_mst    = r_mst;
        n_pos    = r_pos;
        n_cnt    = r_cnt;
        n_halt   = r_halt;
        n_starts = r_starts;
        o_req    = '0;
        o_push   = '0;
        summary  = 1'b0;
        stepped  = 1'b0;
        cap_item = '0;
        sum_item = '0;

        w    = pick(i_rd0, i_rd1);
        nxt  = (w == '0) ? ANY_STATE : w[ST_W-1:0];
        act  = w[WORD_W-1 -: ACT_W];
        cid  = act[CID_W-1:0];
        st   = r_starts[cid];
        cnt1 = CNT_W'(r_cnt + 1'b1);

        unique case (r_state)
            S_CLEAR: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_clr;
                o_req.wdata = '0;
                n_clr       = ADDR_W'(r_clr + 1'b1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (take) begin
                    if (r_in.func == FUNC_LOAD) begin
                        o_req.we    = 1'b1;
                        o_req.waddr = {r_in.table_state, r_in.table_symbol};
                        o_req.wdata = r_in.table_word;
                    end else if (r_halt == STOP_END && r_pos < POS_LIMIT) begin
                        o_req.re     = 1'b1;
                        o_req.raddr0 = {r_mst, r_in.data_byte};
                        o_req.raddr1 = {r_mst, i_wildcard};
                        n_byte       = r_in.data_byte;
                        n_eom        = r_in.end_of_message;
                        n_state      = S_LOOK1;
                    end else begin
                        summary = r_in.end_of_message;
                    end
                end
            end
            S_LOOK1: begin
                stepped = 1'b1;
                if (act[ACT_MATCH]) begin
                    cap_item.kind        = KIND_CAPTURE;
                    cap_item.capture_id  = cid;
                    cap_item.start_res   = st;
                    cap_item.length      = POS_W'(r_pos - st + 1'b1);
                    cap_item.match_count = cnt1;
                    cap_item.stop_reason = STOP_END;
                    cap_item.last        = !r_eom;
                    o_push.push_a        = 1'b1;
                    o_push.item_a        = cap_item;
                    n_cnt                = cnt1;
                    if (cnt1 >= i_limit) begin
                        n_halt  = STOP_LIMIT;
                        stepped = 1'b0;
                    end else begin
                        nxt = ANY_STATE;
                    end
                end else if (act[ACT_DONE]) begin
                    n_halt  = STOP_DONE;
                    stepped = 1'b0;
                end
                n_pos   = POS_W'(r_pos + 1'b1);
                n_state = S_IDLE;
                if (stepped) begin
                    n_mst         = nxt;
                    n_starts[cid] = r_pos;
                end
                if (stepped && nxt == ANY_STATE) begin
                    o_req.re     = 1'b1;
                    o_req.raddr0 = {ANY_STATE, r_byte};
                    o_req.raddr1 = {ANY_STATE, i_wildcard};
                    n_state      = S_LOOK2;
                end else begin
                    summary = r_eom;
                end
            end
            S_LOOK2: begin
                n_mst   = nxt;
                n_state = S_IDLE;
                summary = r_eom;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (summary) begin
            sum_item.kind        = KIND_SUMMARY;
            sum_item.capture_id  = '0;
            sum_item.start_res   = '0;
            sum_item.length      = '0;
            sum_item.match_count = n_cnt;
            sum_item.stop_reason = n_halt;
            sum_item.last        = 1'b1;
            if (o_push.push_a) begin
                o_push.push_b = 1'b1;
                o_push.item_b = sum_item;
            end else begin
                o_push.push_a = 1'b1;
                o_push.item_a = sum_item;
            end
            n_mst  = '0;
            n_pos  = '0;
            n_cnt  = '0;
            n_halt = STOP_END;
            for (int k = 0; k < CAP_SLOTS; k++) begin
                n_starts[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_in_vld <= 1'b0;
            r_mst    <= '0;
            r_pos    <= '0;
            r_cnt    <= '0;
            r_halt   <= STOP_END;
            for (int k = 0; k < CAP_SLOTS; k++) begin
                r_starts[k] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_in_vld <= n_in_vld;
            r_mst    <= n_mst;
            r_pos    <= n_pos;
            r_cnt    <= n_cnt;
            r_halt   <= n_halt;
            r_starts <= n_starts;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
        r_byte <= n_byte;
        r_eom  <= n_eom;
    end

endmodule

[design/dfa_capture_matcher_core.sv]
`timescale 1ns / 1ps

// table-driven dfa matcher: after reset a clearing pass zeroes the 32768-word
// transition table (one transaction can be accepted and held meanwhile, the rest
// wait; config writes still taken). a load transaction is written straight from
// idle; a data byte does one dual read of primary and wildcard entry, then
// evaluates, with a second dual read when the any state is re-entered; bytes
// ignored while halted need no table read.
// the next transaction is buffered while a byte is in flight, and a 4-entry
// result queue decouples the output; a held transaction waits until the queue
// has two free entries.
module dfa_capture_matcher_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  dcm_pkg::t_in_item            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output dcm_pkg::t_out_item           o_out_data,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [dcm_pkg::CFG_W-1:0]    i_cfg_data
);
    import dcm_pkg::*;

    logic [SYM_W-1:0]  r_wildcard;
    logic [CNT_W-1:0]  r_limit;
    t_ram_req          req;
    t_push             push;
    logic [WORD_W-1:0] rd0;
    logic [WORD_W-1:0] rd1;
    logic              free2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wildcard <= WILDCARD_RST;
            r_limit    <= LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WILDCARD: r_wildcard <= i_cfg_data[SYM_W-1:0];
                CFG_LIMIT:    r_limit    <= i_cfg_data[CNT_W-1:0];
            endcase
        end
    end

    dcm_table_ram u_ram (
        .i_clk (i_clk),
        .i_req (req),
        .o_rd0 (rd0),
        .o_rd1 (rd1)
    );

    dcm_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_wildcard (r_wildcard),
        .i_limit    (r_limit),
        .i_free2    (free2),
        .i_rd0      (rd0),
        .i_rd1      (rd1),
        .o_req      (req),
        .o_push     (push)
    );

    dcm_result_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_free2     (free2),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

[dv/tb_dfa_capture_matcher_core.sv]
`timescale 1ns / 1ps

module tb_dfa_capture_matcher_core;
    import dcm_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400_000;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          MAX_PRINTS    = 40;

    class dfa_match_scoreboard;
        bit [WORD_W-1:0] trans_tbl [TBL_DEPTH];
        bit [ST_W-1:0]   cur_state;
        bit [POS_W-1:0]  pos;
        bit [CNT_W-1:0]  found;
        bit [1:0]        halt;
        bit [POS_W-1:0]  cap_start [CAP_SLOTS];
        bit [CFG_W-1:0]  wild;
        bit [CNT_W-1:0]  limit;
        t_out_item       expected_q [$];
        int              mismatches;
        int              checked;
        int              accepted;
        int              messages;

        function new();
            wild  = WILDCARD_RST;
            limit = LIMIT_RST;
            clear_message();
        endfunction

        function void clear_message();
            cur_state = '0;
            pos       = '0;
            found     = '0;
            halt      = STOP_END;
            foreach (cap_start[i]) cap_start[i] = '0;
        endfunction

        function void set_regs(input bit [CFG_W-1:0] w, input bit [CNT_W-1:0] l);
            wild  = w;
            limit = l;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void lookup(input bit [ST_W-1:0] row, input bit [SYM_W-1:0] sym,
                             output bit [ST_W-1:0] nxt, output bit [ACT_W-1:0] act);
            bit [WORD_W-1:0] w;
            w = trans_tbl[{row, sym}];
            if (w == '0) w = trans_tbl[{row, wild}];
            if (w == '0) begin
                nxt = ANY_STATE;
                act = '0;
            end else begin
                nxt = w[ST_W-1:0];
                act = w[WORD_W-1:ACT_W];
            end
        endfunction

        function void note_input(input t_in_item it);
            bit [ST_W-1:0]  nxt;
            bit [ACT_W-1:0] act;
            bit [ACT_W-1:0] act_reentry;
            bit [CID_W-1:0] cid;
            bit [POS_W-1:0] st;
            bit             stepped;
            t_out_item      res;
            accepted++;
            if (it.func == FUNC_LOAD) begin
                trans_tbl[{it.table_state, it.table_symbol}] = it.table_word;
                return;
            end
            if (halt == STOP_END && pos < POS_LIMIT) begin
                lookup(cur_state, it.data_byte, nxt, act);
                cid     = act[CID_W-1:0];
                stepped = 1'b1;
                if (act[ACT_MATCH]) begin
                    st                = cap_start[cid];
                    found             = found + 1'b1;
                    res               = '0;
                    res.kind          = KIND_CAPTURE;
                    res.capture_id    = cid;
                    res.start_res     = st;
                    res.length        = pos - st + 16'd1;
                    res.match_count   = found;
                    res.stop_reason   = STOP_END;
                    res.last          = !it.end_of_message;
                    expected_q.push_back(res);
                    if (found >= limit) begin
                        halt    = STOP_LIMIT;
                        stepped = 1'b0;
                    end else begin
                        nxt = ANY_STATE;
                    end
                end else if (act[ACT_DONE]) begin
                    halt    = STOP_DONE;
                    stepped = 1'b0;
                end
                if (stepped) begin
                    cur_state      = nxt;
                    cap_start[cid] = pos;
                    // any state is re-entered on the same byte, its action dropped
                    if (cur_state == ANY_STATE) begin
                        lookup(ANY_STATE, it.data_byte, nxt, act_reentry);
                        cur_state = nxt;
                    end
                end
                pos = pos + 16'd1;
            end
            if (it.end_of_message) begin
                res             = '0;
                res.kind        = KIND_SUMMARY;
                res.match_count = found;
                res.stop_reason = halt;
                res.last        = 1'b1;
                expected_q.push_back(res);
                messages++;
                clear_message();
            end
        endfunction

        task report_mismatch(input string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTS) $display("mismatch: %s", msg);
        endtask

        task check_result(input t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing outstanding", got));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.kind !== want.kind)
                report_mismatch($sformatf("result %0d kind got %0d want %0d",
                                          checked, got.kind, want.kind));
            if (got.capture_id !== want.capture_id)
                report_mismatch($sformatf("result %0d capture_id got %0d want %0d",
                                          checked, got.capture_id, want.capture_id));
            if (got.start_res !== want.start_res)
                report_mismatch($sformatf("result %0d start_res got %0d want %0d",
                                          checked, got.start_res, want.start_res));
            if (got.length !== want.length)
                report_mismatch($sformatf("result %0d length got %0d want %0d",
                                          checked, got.length, want.length));
            if (got.match_count !== want.match_count)
                report_mismatch($sformatf("result %0d match_count got %0d want %0d",
                                          checked, got.match_count, want.match_count));
            if (got.stop_reason !== want.stop_reason)
                report_mismatch($sformatf("result %0d stop_reason got %0d want %0d",
                                          checked, got.stop_reason, want.stop_reason));
            if (got.last !== want.last)
                report_mismatch($sformatf("result %0d last got %0d want %0d",
                                          checked, got.last, want.last));
        endtask
    endclass

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             in_valid = 1'b0;
    t_in_item         in_data  = '0;
    logic             in_ready;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out_item        out_data;
    logic             cfg_we   = 1'b0;
    logic             cfg_idx  = CFG_WILDCARD;
    logic [CFG_W-1:0] cfg_data = '0;

    int unsigned cycle_count   = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_token    = 0;
    int          hold_seen     = 0;
    int          hold_left     = 0;

    dfa_match_scoreboard matcher;

    dfa_capture_matcher_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, matcher.pending());
        $display("TB_ERROR");
        $finish;
    end

    // result side: check, then choose ready for the next cycle
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_ready) matcher.check_result(out_data);
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic t_in_item load_item(input bit [ST_W-1:0] row,
                                           input bit [SYM_W-1:0] sym,
                                           input bit [WORD_W-1:0] word);
        bit [63:0] r;
        t_in_item  it;
        r                = {$urandom, $urandom};
        it               = r[$bits(t_in_item)-1:0];
        it.func          = FUNC_LOAD;
        it.table_state   = row;
        it.table_symbol  = sym;
        it.table_word    = word;
        return it;
    endfunction

    function automatic t_in_item data_item(input bit [SYM_W-1:0] b, input bit eom);
        bit [63:0] r;
        t_in_item  it;
        r                 = {$urandom, $urandom};
        it                = r[$bits(t_in_item)-1:0];
        it.func           = FUNC_DATA;
        it.data_byte      = b;
        it.end_of_message = eom;
        return it;
    endfunction

    function automatic bit [SYM_W-1:0] pick_byte();
        bit [31:0] r;
        int        sel;
        r   = $urandom;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2: return r[SYM_W-1:0];
            3:       return matcher.wild;
            4:       return 8'h00;
            5:       return 8'hFF;
            6:       return 8'h5A;
            7:       return 8'hA5;
            default: return 8'h3C;
        endcase
    endfunction

    function automatic bit [WORD_W-1:0] random_word();
        bit [31:0]      r;
        bit [31:0]      r2;
        bit [ACT_W-1:0] act;
        bit [15:0]      nxt;
        r  = $urandom;
        r2 = $urandom_range(0, 7);
        nxt = ($urandom_range(0, 4) == 0) ? r[15:0] : {9'd0, r2[ST_W-1:0]};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return r;
            2:       act = {2'b10, r[29:16]};
            3:       act = {2'b01, r[29:16]};
            default: act = {2'b00, r[29:16]};
        endcase
        return {act, nxt};
    endfunction

    function automatic t_in_item random_load();
        bit [31:0]     r;
        bit [ST_W-1:0] row;
        r   = $urandom;
        row = ($urandom_range(0, 99) < 85) ? {4'd0, r[2:0]} : r[ST_W-1:0];
        return load_item(row, pick_byte(), random_word());
    endfunction

    task automatic send_item(input t_in_item item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_ready !== 1'b1);
        matcher.note_input(item);
    endtask

    task automatic send_data(input bit [SYM_W-1:0] b, input bit eom);
        send_item(data_item(b, eom));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (matcher.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input bit [CFG_W-1:0] wild, input bit [CNT_W-1:0] lim);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_WILDCARD;
        cfg_data <= wild;
        @(posedge clk);
        cfg_idx  <= CFG_LIMIT;
        cfg_data <= {4'd0, lim};
        @(posedge clk);
        cfg_we   <= 1'b0;
        matcher.set_regs(wild, lim);
    endtask

    task automatic run_directed();
        send_item(load_item(7'd127, 8'hFF, 32'hFFFF_FFFF));
        // wildcard column with a wide next state folding to state 3
        send_item(load_item(7'd0, WILDCARD_RST, {16'h0002, 16'hFF83}));
        send_item(load_item(7'd3, 8'h10, {16'h8002, 16'h0004}));
        send_item(load_item(7'd3, 8'h11, {16'h4000, 16'h0000}));
        send_item(load_item(7'd1, 8'h20, {16'h0002, 16'h0003}));
        send_data(8'h20, 1'b0);
        send_data(8'h10, 1'b0);
        send_data(8'h20, 1'b0);
        send_data(8'h00, 1'b1);
        // done action, later bytes ignored
        send_data(8'h20, 1'b0);
        send_data(8'h11, 1'b0);
        send_data(8'h10, 1'b0);
        send_data(8'h10, 1'b1);
        settle();
        write_regs(WILDCARD_RST, 4'd0);
        send_data(8'h20, 1'b0);
        send_data(8'h10, 1'b1);
        settle();
        write_regs(WILDCARD_RST, 4'd2);
        send_data(8'h20, 1'b0);
        send_data(8'h10, 1'b0);
        send_data(8'h20, 1'b0);
        send_item(load_item(7'd3, 8'hFF, 32'h0000_0001));
        send_data(8'h10, 1'b0);
        send_data(8'hFF, 1'b1);
        send_data(8'hFF, 1'b1);
    endtask

    task automatic run_random_phase(input int n_items);
        int sent;
        int msg_len;
        sent = 0;
        while (sent < n_items) begin
            msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
            for (int k = 0; k < msg_len; k++) begin
                if ($urandom_range(0, 99) < 15) begin
                    send_item(random_load());
                    sent++;
                end
                send_data(pick_byte(), k == msg_len - 1);
                sent++;
            end
        end
    endtask

    initial begin
        matcher = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        settle();

        write_regs(8'h00, 4'd15);
        send_idle_pct <= 24;
        recv_idle_pct <= 49;
        run_random_phase(470);
        settle();

        write_regs(8'hFF, 4'd3);
        send_idle_pct <= 49;
        recv_idle_pct <= 24;
        run_random_phase(470);
        settle();

        // long receiver hold so the result queue backs up into the input
        write_regs(WILDCARD_RST, 4'd1);
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        hold_token    <= hold_token + 1;
        run_random_phase(470);
        settle();

        $display("ran %0d input transactions over %0d messages, checked %0d results",
                 matcher.accepted, matcher.messages, matcher.checked);
        $display("wildcard at 0, 42 and 255, match limit 0 to 15, %0d mismatches",
                 matcher.mismatches);
        if (matcher.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
